// ----- hw/rtl/u8d_pkg.sv -----
// Package for the UTF-8 stream decoder: result type and lead-byte constants.
// No dependencies; used by u8d_core and utf8_stream_decoder.
package u8d_pkg;

    // Widths fixed by the stream format.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 31;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned PAYLOAD_W = 6;

    // Byte classification constants.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MAX  = 8'hF7;
    localparam logic [7:0] LEAD5_MAX  = 8'hFB;
    localparam logic [7:0] LEAD6_MAX  = 8'hFD;

    // One decoded result.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_sequence;
    } t_result;

endpackage

// ----- hw/rtl/u8d_core.sv -----
// Decode core of the UTF-8 stream decoder: input byte register, sequence
// state and the single-pass decode into one result. Depends on u8d_pkg.
module u8d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,     // capture a new byte this cycle
    input  logic [7:0]         i_byte,
    input  logic               i_advance,  // decode the held byte this cycle
    output logic               o_held,     // a byte is held for decode
    output logic               o_res_valid,
    output u8d_pkg::t_result   o_res
);
    import u8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [PEND_W-1:0] r_pending;
    logic [CP_W-1:0]   r_accum;
    logic              r_error;

    logic [PEND_W-1:0] n_pending;
    logic [CP_W-1:0]   n_accum;
    logic              n_error;
    logic              n_in_valid;
    logic [CP_W-1:0]   cont_accum;
    logic              cont_bad;
    logic [PEND_W-1:0] pend_dec;

    // Continuation path: shift six payload bits in.
    assign cont_accum = {r_accum[CP_W-PAYLOAD_W-1:0], r_in_byte[PAYLOAD_W-1:0]};
    assign cont_bad   = (r_in_byte & CONT_MASK) != CONT_TAG;
    assign pend_dec   = r_pending - PEND_W'(1);

    // Next state and result for the held byte.
    always_comb begin
        n_pending   = r_pending;
        n_accum     = r_accum;
        n_error     = r_error;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_pending != '0) begin
            n_pending = pend_dec;
            if (pend_dec == '0) begin
                o_res_valid        = 1'b1;
                o_res.bad_sequence = r_error | cont_bad;
                o_res.code_point   = (r_error | cont_bad) ? '0 : cont_accum;
                n_accum            = '0;
                n_error            = 1'b0;
            end else begin
                n_accum = cont_accum;
                n_error = r_error | cont_bad;
            end
        end else if (r_in_byte <= ASCII_MAX) begin
            o_res_valid      = 1'b1;
            o_res.code_point = CP_W'(r_in_byte);
        end else if (r_in_byte < LEAD_MIN || r_in_byte > LEAD6_MAX) begin
            // Stray continuation byte or an invalid lead.
            o_res_valid        = 1'b1;
            o_res.bad_sequence = 1'b1;
        end else begin
            n_error = 1'b0;
            if (r_in_byte <= LEAD2_MAX) begin
                n_accum   = CP_W'(r_in_byte[4:0]);
                n_pending = PEND_W'(1);
            end else if (r_in_byte <= LEAD3_MAX) begin
                n_accum   = CP_W'(r_in_byte[3:0]);
                n_pending = PEND_W'(2);
            end else if (r_in_byte <= LEAD4_MAX) begin
                n_accum   = CP_W'(r_in_byte[2:0]);
                n_pending = PEND_W'(3);
            end else if (r_in_byte <= LEAD5_MAX) begin
                n_accum   = CP_W'(r_in_byte[1:0]);
                n_pending = PEND_W'(4);
            end else begin
                n_accum   = CP_W'(r_in_byte[0]);
                n_pending = PEND_W'(5);
            end
        end
        if (!r_in_valid) begin
            o_res_valid = 1'b0;
        end
    end

    assign n_in_valid = i_load | (r_in_valid & ~i_advance);
    assign o_held     = r_in_valid;

    // Input byte register and sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pending  <= '0;
            r_accum    <= '0;
            r_error    <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_advance && r_in_valid) begin
                r_pending <= n_pending;
                r_accum   <= n_accum;
                r_error   <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in_byte <= i_byte;
        end
    end

endmodule

// ----- hw/rtl/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: stream ports, core and output skid.
// Depends on u8d_pkg and u8d_core.
//
// Decodes a UTF-8 byte stream, legacy 31-bit form with sequences of one to
// six bytes, into one code point per completed sequence. One byte is taken
// per cycle back to back unless stalled; a byte goes through an input
// register and one pass of decode logic into a two-entry output buffer:
// the output register or, while that holds a refused beat, the skid
// slot. The input stalls only while the skid slot of the output buffer
// holds a beat, which happens only when the downstream side has refused a
// beat. Bytes that only open or extend a sequence give no beat. A stray
// continuation byte, 0xFE or 0xFF gives a beat of its own with bad_sequence
// set; a sequence with a malformed continuation byte is still consumed to
// its full length and its beat has bad_sequence set. Code point is zero
// whenever bad_sequence is set.
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] code_point, [31] zero fill
    output logic        m_axis_tuser    // [0] bad_sequence
);
    import u8d_pkg::*;

    logic    core_held;
    logic    core_advance;
    logic    core_res_valid;
    t_result core_res;
    logic    in_load;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    out_take;
    logic    push;

    // The held byte decodes whenever the skid slot is free.
    assign core_advance  = core_held & ~r_skid_valid;
    assign s_axis_tready = ~core_held | core_advance;
    assign in_load       = s_axis_tvalid & s_axis_tready;
    assign push          = core_advance & core_res_valid;
    assign out_take      = r_out_valid & m_axis_tready;

    u8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_load),
        .i_byte      (s_axis_tdata),
        .i_advance   (core_advance),
        .o_held      (core_held),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // Output register with skid slot behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= push;
                end else begin
                    r_out_valid <= push;
                end
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (push) begin
                    r_skid <= core_res;
                end
            end else if (push) begin
                r_out <= core_res;
            end
        end else if (push) begin
            r_skid <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.code_point};
    assign m_axis_tuser  = r_out.bad_sequence;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for utf8_stream_decoder: directed and random UTF-8
// byte streams in, code points checked against an in-line decoder model.
// Depends on u8d_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;

    import u8d_pkg::*;

    // Settling wait at a drain point, with margin over the result latency.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned RANDOM_BYTES  = 450;
    localparam int unsigned CALM_FIRST    = 200;
    localparam int unsigned CALM_LAST     = 400;

    // One entry of the byte feed: a byte, or a point where the feed waits
    // until every open result has come back.
    typedef struct {
        logic       drain;
        logic [7:0] value;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [30:0] code_point, [31] zero fill
    logic        m_axis_tuser;         // [0] bad_sequence

    t_feed       byte_feed[$];
    t_result     open_results[$];

    // Decoder model state.
    logic [PEND_W-1:0] cont_left = '0;
    logic [CP_W-1:0]   payload_acc = '0;
    logic              seq_broken = 1'b0;

    int unsigned cycle_cnt = 0;
    int unsigned settle_cnt = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned bad_seen = 0;
    int unsigned fail_cnt = 0;
    t_result     got;

    utf8_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random idling, except in a window where both sides run flat out.
    function automatic logic idle_now();
        if (cycle_cnt >= CALM_FIRST && cycle_cnt < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 10;
    endfunction

    // Advances the decoder model by one accepted byte and queues any result.
    task automatic decode_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (cont_left != 0) begin
            if ((b & CONT_MASK) != CONT_TAG) begin
                seq_broken = 1'b1;
            end
            payload_acc = {payload_acc[CP_W-PAYLOAD_W-1:0], b[PAYLOAD_W-1:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) begin
                r.bad_sequence = seq_broken;
                r.code_point   = seq_broken ? '0 : payload_acc;
                open_results.push_back(r);
                payload_acc = '0;
                seq_broken  = 1'b0;
            end
        end else if (b <= ASCII_MAX) begin
            r.code_point = CP_W'(b);
            open_results.push_back(r);
        end else if (b < LEAD_MIN || b > LEAD6_MAX) begin
            // Stray continuation byte or 0xFE/0xFF: flagged on its own.
            r.bad_sequence = 1'b1;
            open_results.push_back(r);
        end else begin
            seq_broken = 1'b0;
            if (b <= LEAD2_MAX) begin
                payload_acc = CP_W'(b[4:0]);
                cont_left   = 3'd1;
            end else if (b <= LEAD3_MAX) begin
                payload_acc = CP_W'(b[3:0]);
                cont_left   = 3'd2;
            end else if (b <= LEAD4_MAX) begin
                payload_acc = CP_W'(b[2:0]);
                cont_left   = 3'd3;
            end else if (b <= LEAD5_MAX) begin
                payload_acc = CP_W'(b[1:0]);
                cont_left   = 3'd4;
            end else begin
                payload_acc = CP_W'(b[0]);
                cont_left   = 3'd5;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_feed f;
        f.drain = 1'b0;
        f.value = b;
        byte_feed.push_back(f);
        bytes_queued++;
    endtask

    task automatic push_drain();
        t_feed f;
        f.drain = 1'b1;
        f.value = '0;
        byte_feed.push_back(f);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
        end
    end

    // Driver: predicts on each accepted beat, then offers the next byte.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Beat still on offer; hold it.
            end else if (byte_feed.size() != 0 && byte_feed[0].drain) begin
                s_axis_tvalid <= 1'b0;
                if (open_results.size() != 0) begin
                    settle_cnt = 0;
                end else if (settle_cnt < SETTLE_CYCLES) begin
                    settle_cnt++;
                end else begin
                    settle_cnt = 0;
                    void'(byte_feed.pop_front());
                end
            end else if (byte_feed.size() != 0 && !idle_now()) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= byte_feed[0].value;
                void'(byte_feed.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (open_results.size() == 0) begin
                $error("unexpected result beat: code_point 0x%08h bad_sequence %0b",
                       m_axis_tdata[CP_W-1:0], m_axis_tuser);
                fail_cnt++;
            end else begin
                got = open_results.pop_front();
                results_seen++;
                if (got.bad_sequence) begin
                    bad_seen++;
                end
                if (m_axis_tdata[CP_W-1:0] !== got.code_point) begin
                    $error("code_point: expected 0x%08h, actual 0x%08h",
                           got.code_point, m_axis_tdata[CP_W-1:0]);
                    fail_cnt++;
                end
                if (m_axis_tuser !== got.bad_sequence) begin
                    $error("bad_sequence: expected %0b, actual %0b",
                           got.bad_sequence, m_axis_tuser);
                    fail_cnt++;
                end
            end
        end
        m_axis_tready <= i_rst_n ? !idle_now() : 1'b0;
    end

    // Stimulus and end of run.
    initial begin
        int unsigned pick;
        int unsigned seq_len;
        logic [7:0]  lead;
        logic        corrupt;
        logic        drained;

        // Single bytes: ASCII extremes, stray continuations, invalid leads.
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hBF);
        push_byte(8'hFE);
        push_byte(8'hFF);
        // Overlong two-byte form and the top of the two-byte range.
        push_byte(8'hC0); push_byte(8'h80);
        push_byte(8'hDF); push_byte(8'hBF);
        // Three-, four- and five-byte forms at their extremes.
        push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
        push_byte(8'hF8);
        repeat (4) push_byte(8'h80);
        // Largest six-byte value, 0x7FFFFFFF.
        push_byte(8'hFD);
        repeat (5) push_byte(8'hBF);
        // Malformed continuation, then a lead byte inside an open sequence.
        push_byte(8'hC2); push_byte(8'h41);
        push_byte(8'hE2); push_byte(8'hC3); push_byte(8'h80);
        push_drain();

        // Mostly well-formed sequences with random payload, some noise.
        drained = 1'b0;
        while (bytes_queued < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                seq_len = $urandom_range(1, 6);
                case (seq_len)
                    1: lead = 8'($urandom_range(8'h00, ASCII_MAX));
                    2: lead = 8'($urandom_range(LEAD_MIN, LEAD2_MAX));
                    3: lead = 8'($urandom_range(LEAD2_MAX + 1, LEAD3_MAX));
                    4: lead = 8'($urandom_range(LEAD3_MAX + 1, LEAD4_MAX));
                    5: lead = 8'($urandom_range(LEAD4_MAX + 1, LEAD5_MAX));
                    default: lead = 8'($urandom_range(LEAD5_MAX + 1, LEAD6_MAX));
                endcase
                push_byte(lead);
                corrupt = pick < 25;
                for (int i = 1; i < seq_len; i++) begin
                    if (corrupt && $urandom_range(0, 2) == 0) begin
                        push_byte(8'($urandom_range(0, 255)));
                    end else begin
                        push_byte(CONT_TAG | 8'($urandom_range(0, 63)));
                    end
                end
            end
            // One full pause in mid-stream, at a sequence boundary.
            if (!drained && bytes_queued > 250) begin
                push_drain();
                drained = 1'b1;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (byte_feed.size() != 0 || s_axis_tvalid || open_results.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("Decoded %0d bytes into %0d checked results, %0d of them flagged bad.",
                 bytes_taken, results_seen, bad_seen);
        $display("Covered lengths 1 to 6, stray and invalid leads, malformed continuations.");
        if (fail_cnt == 0 && open_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding.", open_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
